// ===== rtl/ffa_pkg.sv =====
`default_nettype none
package ffa_pkg;

    localparam int unsigned ARENA_BYTES_DEF = 4096;
    localparam int unsigned ARENA_RST       = 4096;
    localparam int unsigned SPILL_RST       = 128;
    localparam int unsigned LEN_W           = 24;
    localparam int unsigned ENT_W           = LEN_W + 1;
    localparam int unsigned POS_W           = 25;
    localparam int unsigned CFG_W           = 13;
    localparam int unsigned SPILL_W         = 12;
    localparam int unsigned OFF_W           = 12;
    localparam int unsigned HDR_BYTES       = 4;
    localparam int unsigned MIN_PARTIAL     = 8;
    localparam int unsigned MIN_ARENA       = 8;

    // request kinds
    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_GROW  = 2'd1;
    localparam logic [1:0] FUNC_FREE  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ARENA = 2'd0;
    localparam logic [1:0] CFG_SPILL = 2'd1;

    typedef enum logic [9:0] {
        S_INIT = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_WRD  = 10'b0000000100,
        S_WCHK = 10'b0000001000,
        S_NRD  = 10'b0000010000,
        S_NCHK = 10'b0000100000,
        S_DEC  = 10'b0001000000,
        S_TAKE = 10'b0010000000,
        S_WR   = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    // header position still inside the arena
    function automatic logic in_arena(input logic [POS_W-1:0] p,
                                      input logic [CFG_W-1:0] arena);
        logic [POS_W-1:0] e;
        e = p + POS_W'(HDR_BYTES);
        return e <= POS_W'(arena);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/first_fit_arena_allocator_top.sv =====
`default_nettype none
// The sequencer walks the header chain through the single read port of the
// header memory (no walk for a request rejected on its fields, one walk for
// allocate/free, two for a relocating grow). One request at a time; the next
// request is taken in the cycle after the result is taken.
// Reset (synchronous, active low) restores arena size and spill threshold; the
// INIT state then writes the initial free header at offset zero.
module first_fit_arena_allocator_top #(
    parameter int unsigned ARENA_BYTES = ffa_pkg::ARENA_BYTES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [1:0]                 i_func,
    input  wire logic [ffa_pkg::OFF_W-1:0]  i_offset,
    input  wire logic [ffa_pkg::LEN_W-1:0]  i_size,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [1:0]                      o_status,
    output logic [ffa_pkg::OFF_W-1:0]       o_result_offset,
    output logic                            o_move_valid,
    output logic [ffa_pkg::OFF_W-1:0]       o_move_from,
    output logic [ffa_pkg::OFF_W-1:0]       o_move_length,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [ffa_pkg::CFG_W-1:0]  i_cfg_data
);
    localparam int unsigned AW = $clog2(ARENA_BYTES);
    localparam int unsigned PW = ffa_pkg::POS_W;
    localparam int unsigned LW = ffa_pkg::LEN_W;
    localparam int unsigned EW = ffa_pkg::ENT_W;
    localparam int unsigned CW = ffa_pkg::CFG_W;
    localparam int unsigned OW = ffa_pkg::OFF_W;
    localparam int unsigned ARST = (ffa_pkg::ARENA_RST > ARENA_BYTES) ?
                                   ARENA_BYTES : ffa_pkg::ARENA_RST;

    ffa_pkg::t_state r_state, n_state;
    logic [1:0]      r_func, n_func;
    logic [OW-1:0]   r_off, n_off;
    logic [LW-1:0]   r_size, n_size;
    logic            r_find, n_find;
    logic            r_reloc, n_reloc;
    logic [PW-1:0]   r_pos, n_pos;
    logic [LW-1:0]   r_need, n_need;
    logic [PW-1:0]   r_h, n_h;
    logic [LW-1:0]   r_hlen, n_hlen;
    logic [PW-1:0]   r_nx, n_nx;
    logic            r_sfree, n_sfree;
    logic [LW-1:0]   r_nlen, n_nlen;
    logic [PW-1:0]   r_a, n_a;
    logic [LW-1:0]   r_alen, n_alen;
    logic [AW-1:0]   r_wa [3];
    logic [AW-1:0]   n_wa [3];
    logic [EW-1:0]   r_wd [3];
    logic [EW-1:0]   n_wd [3];
    logic [1:0]      r_wn, n_wn;
    logic [1:0]      r_wi, n_wi;
    logic [1:0]      r_status, n_status;
    logic [OW-1:0]   r_res, n_res;
    logic            r_mv, n_mv;
    logic [OW-1:0]   r_mfrom, n_mfrom;
    logic [OW-1:0]   r_mlen, n_mlen;
    logic [CW-1:0]   r_arena, n_arena;
    logic [ffa_pkg::SPILL_W-1:0] r_spill, n_spill;

    logic          ram_we;
    logic [AW-1:0] ram_wa, ram_ra;
    logic [EW-1:0] ram_wd, ram_rd;

    ffa_ram #(.W(EW), .D(ARENA_BYTES)) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (ram_ra),
        .o_rdata (ram_rd)
    );

    assign o_stall         = (r_state != ffa_pkg::S_IDLE);
    assign o_valid         = (r_state == ffa_pkg::S_OUT);
    assign o_status        = r_status;
    assign o_result_offset = r_res;
    assign o_move_valid    = r_mv;
    assign o_move_from     = r_mfrom;
    assign o_move_length   = r_mlen;

    // sequencer: chain walk, successor probe, header updates
    always_comb begin
        logic [LW-1:0] rd_len;
        logic          rd_alloc;
        logic [PW-1:0] step;
        logic [PW-1:0] gsum;
        logic [LW-1:0] rel;
        logic [LW-1:0] keep;
        logic [LW-1:0] rest;
        logic [LW-1:0] want;
        logic [1:0]    k;
        logic [CW-1:0] clamp;

        rd_len   = ram_rd[LW-1:0];
        rd_alloc = ram_rd[LW];
        step     = r_pos + PW'(ffa_pkg::HDR_BYTES) + PW'(rd_len);
        gsum     = PW'(r_hlen) + PW'(r_size);
        rel      = r_sfree ? (r_hlen + LW'(ffa_pkg::HDR_BYTES) + r_nlen) : r_hlen;
        keep     = r_hlen - r_size;
        rest     = r_alen - r_need;
        want     = r_need;
        k        = 2'd0;
        clamp    = i_cfg_data;

        n_state = r_state; n_func = r_func; n_off = r_off; n_size = r_size;
        n_find = r_find; n_reloc = r_reloc; n_pos = r_pos; n_need = r_need;
        n_h = r_h; n_hlen = r_hlen; n_nx = r_nx; n_sfree = r_sfree;
        n_nlen = r_nlen; n_a = r_a; n_alen = r_alen;
        n_wa = r_wa; n_wd = r_wd; n_wn = r_wn; n_wi = r_wi;
        n_status = r_status; n_res = r_res; n_mv = r_mv;
        n_mfrom = r_mfrom; n_mlen = r_mlen;
        n_arena = r_arena; n_spill = r_spill;

        ram_we = 1'b0;
        ram_wa = '0;
        ram_wd = '0;
        ram_ra = r_pos[AW-1:0];

        unique case (r_state)
            ffa_pkg::S_INIT: begin
                ram_we  = 1'b1;
                ram_wd  = EW'(r_arena - CW'(ffa_pkg::HDR_BYTES));
                n_state = ffa_pkg::S_IDLE;
            end
            ffa_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_func = i_func; n_off = i_offset; n_size = i_size;
                    n_status = ffa_pkg::ST_REJECT; n_res = '0; n_mv = 1'b0;
                    n_mfrom = '0; n_mlen = '0;
                    n_pos = '0; n_need = i_size; n_reloc = 1'b0;
                    n_state = ffa_pkg::S_OUT;
                    if (i_func == ffa_pkg::FUNC_ALLOC) begin
                        if (i_size != '0) begin
                            n_find = 1'b1; n_state = ffa_pkg::S_WRD;
                        end
                    end else if (i_func == ffa_pkg::FUNC_GROW ||
                                 i_func == ffa_pkg::FUNC_FREE) begin
                        if (i_offset >= OW'(ffa_pkg::HDR_BYTES) &&
                            (i_size != '0 || i_func == ffa_pkg::FUNC_FREE)) begin
                            n_find = 1'b0; n_state = ffa_pkg::S_WRD;
                        end
                    end
                end
            end
            // issue header read, or end the walk at the arena end
            ffa_pkg::S_WRD: begin
                if (ffa_pkg::in_arena(r_pos, r_arena)) begin
                    n_state = ffa_pkg::S_WCHK;
                end else begin
                    n_status = r_find ? ffa_pkg::ST_NOSPACE : ffa_pkg::ST_REJECT;
                    n_state  = ffa_pkg::S_OUT;
                end
            end
            ffa_pkg::S_WCHK: begin
                n_pos   = step;
                n_state = ffa_pkg::S_WRD;
                if (r_find) begin
                    if (!rd_alloc && rd_len >= r_need) begin
                        n_a = r_pos; n_alen = rd_len; n_state = ffa_pkg::S_TAKE;
                    end
                end else if (r_pos + PW'(ffa_pkg::HDR_BYTES) == PW'(r_off)) begin
                    if (rd_alloc) begin
                        n_h = r_pos; n_hlen = rd_len; n_nx = step;
                        n_state = ffa_pkg::S_NRD;
                    end else begin
                        n_state = ffa_pkg::S_OUT;
                    end
                end
            end
            // probe the successor header
            ffa_pkg::S_NRD: begin
                ram_ra  = r_nx[AW-1:0];
                n_sfree = 1'b0;
                n_state = ffa_pkg::in_arena(r_nx, r_arena) ? ffa_pkg::S_NCHK :
                                                              ffa_pkg::S_DEC;
            end
            ffa_pkg::S_NCHK: begin
                n_sfree = !rd_alloc; n_nlen = rd_len;
                n_state = ffa_pkg::S_DEC;
            end
            ffa_pkg::S_DEC: begin
                n_wi = 2'd0;
                n_state = ffa_pkg::S_OUT;
                if (r_func == ffa_pkg::FUNC_GROW) begin
                    if (r_sfree && r_nlen >= r_size) begin
                        n_wa[0] = r_h[AW-1:0];
                        n_wd[0] = {1'b1, r_hlen + r_size};
                        n_wa[1] = AW'(r_nx + PW'(r_size));
                        n_wd[1] = {1'b0, r_nlen - r_size};
                        n_wn = 2'd2; n_status = ffa_pkg::ST_DONE; n_res = r_off;
                        n_state = ffa_pkg::S_WR;
                    end else if (gsum[PW-1]) begin
                        n_status = ffa_pkg::ST_NOSPACE;
                    end else begin
                        n_need = gsum[LW-1:0]; n_find = 1'b1; n_reloc = 1'b1;
                        n_pos = '0; n_state = ffa_pkg::S_WRD;
                    end
                end else if (r_size == '0 || r_size == r_hlen) begin
                    n_wa[0] = r_h[AW-1:0];
                    n_wd[0] = {1'b0, rel};
                    n_wn = 2'd1; n_status = ffa_pkg::ST_DONE; n_res = r_off;
                    n_state = ffa_pkg::S_WR;
                end else if (r_size >= LW'(ffa_pkg::MIN_PARTIAL) && r_size < r_hlen) begin
                    n_wa[0] = r_h[AW-1:0];
                    n_wd[0] = {1'b1, keep};
                    if (r_sfree) begin
                        n_wa[1] = AW'(r_nx - PW'(r_size));
                        n_wd[1] = {1'b0, r_nlen + r_size};
                    end else begin
                        n_wa[1] = AW'(r_h + PW'(ffa_pkg::HDR_BYTES) + PW'(keep));
                        n_wd[1] = {1'b0, r_size - LW'(ffa_pkg::HDR_BYTES)};
                    end
                    n_wn = 2'd2; n_status = ffa_pkg::ST_DONE; n_res = r_off;
                    n_state = ffa_pkg::S_WR;
                end
            end
            // take the found block, splitting off a large enough rest; a relocation first frees the old one
            ffa_pkg::S_TAKE: begin
                if (r_reloc) begin
                    n_wa[0] = r_h[AW-1:0];
                    n_wd[0] = {1'b0, rel};
                    k = 2'd1;
                    n_mv = 1'b1; n_mfrom = r_off; n_mlen = r_hlen[OW-1:0];
                end
                if (rest < LW'(r_spill) || rest < LW'(ffa_pkg::HDR_BYTES)) begin
                    want = r_alen;
                end else begin
                    n_wa[k] = AW'(r_a + PW'(ffa_pkg::HDR_BYTES) + PW'(r_need));
                    n_wd[k] = {1'b0, rest - LW'(ffa_pkg::HDR_BYTES)};
                    k = k + 2'd1;
                end
                n_wa[k] = r_a[AW-1:0];
                n_wd[k] = {1'b1, want};
                n_wn = k + 2'd1; n_wi = 2'd0;
                n_status = ffa_pkg::ST_DONE;
                n_res = OW'(r_a + PW'(ffa_pkg::HDR_BYTES));
                n_state = ffa_pkg::S_WR;
            end
            ffa_pkg::S_WR: begin
                ram_we = 1'b1;
                ram_wa = r_wa[r_wi];
                ram_wd = r_wd[r_wi];
                n_wi   = r_wi + 2'd1;
                if (r_wi == r_wn - 2'd1) begin
                    n_state = ffa_pkg::S_OUT;
                end
            end
            ffa_pkg::S_OUT: begin
                if (!i_stall) begin
                    n_state = ffa_pkg::S_IDLE;
                end
            end
            default: n_state = ffa_pkg::S_IDLE;
        endcase

        // configuration writes; arena size rebuilds the first header
        if (i_cfg_we && i_cfg_idx == ffa_pkg::CFG_ARENA) begin
            if (i_cfg_data < CW'(ffa_pkg::MIN_ARENA)) begin
                clamp = CW'(ffa_pkg::MIN_ARENA);
            end else if (PW'(i_cfg_data) > PW'(ARENA_BYTES)) begin
                clamp = CW'(ARENA_BYTES);
            end
            n_arena = clamp;
            ram_we  = 1'b1;
            ram_wa  = '0;
            ram_wd  = EW'(clamp - CW'(ffa_pkg::HDR_BYTES));
            if (r_state == ffa_pkg::S_INIT) begin
                n_state = ffa_pkg::S_IDLE;
            end
        end
        if (i_cfg_we && i_cfg_idx == ffa_pkg::CFG_SPILL) begin
            n_spill = i_cfg_data[ffa_pkg::SPILL_W-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffa_pkg::S_INIT;
            r_arena <= CW'(ARST);
            r_spill <= ffa_pkg::SPILL_W'(ffa_pkg::SPILL_RST);
            r_wn    <= '0;
            r_wi    <= '0;
        end else begin
            r_state <= n_state;
            r_arena <= n_arena;
            r_spill <= n_spill;
            r_wn    <= n_wn;
            r_wi    <= n_wi;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func <= n_func; r_off <= n_off; r_size <= n_size;
        r_find <= n_find; r_reloc <= n_reloc; r_pos <= n_pos; r_need <= n_need;
        r_h <= n_h; r_hlen <= n_hlen; r_nx <= n_nx; r_sfree <= n_sfree;
        r_nlen <= n_nlen; r_a <= n_a; r_alen <= n_alen;
        r_wa <= n_wa; r_wd <= n_wd;
        r_status <= n_status; r_res <= n_res; r_mv <= n_mv;
        r_mfrom <= n_mfrom; r_mlen <= n_mlen;
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != ffa_pkg::S_IDLE))
        else $error("request accepted but sequencer idle");
    a_wchk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffa_pkg::S_WCHK) |-> ($past(r_state) == ffa_pkg::S_WRD))
        else $error("header check without read");
    a_wq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffa_pkg::S_WR) |-> (r_wi < r_wn))
        else $error("write queue overrun");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_move_valid) |-> (o_status == ffa_pkg::ST_DONE))
        else $error("move request without success");

endmodule
`default_nettype wire

// ===== rtl/ffa_ram.sv =====
`default_nettype none
module ffa_ram #(
    parameter int unsigned W = 25,
    parameter int unsigned D = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;

    localparam int unsigned ARENA_MAX  = 4096;
    localparam int unsigned IDLE_LIMIT = 40000;
    localparam int unsigned OW         = ffa_pkg::OFF_W;
    localparam int unsigned LW         = ffa_pkg::LEN_W;
    localparam int unsigned EW         = ffa_pkg::ENT_W;
    localparam int unsigned HB         = ffa_pkg::HDR_BYTES;

    typedef struct packed {
        logic [1:0]    status;
        logic [OW-1:0] result_offset;
        logic          move_valid;
        logic [OW-1:0] move_from;
        logic [OW-1:0] move_length;
    } t_alloc_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [1:0]                 i_func = ffa_pkg::FUNC_ALLOC;
    logic [OW-1:0]              i_offset = '0;
    logic [LW-1:0]              i_size = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [1:0]                 o_status;
    logic [OW-1:0]              o_result_offset;
    logic                       o_move_valid;
    logic [OW-1:0]              o_move_from;
    logic [OW-1:0]              o_move_length;
    logic                       i_cfg_we = 1'b0;
    logic [1:0]                 i_cfg_idx = ffa_pkg::CFG_ARENA;
    logic [ffa_pkg::CFG_W-1:0]  i_cfg_data = '0;

    first_fit_arena_allocator_top dut (.*);

    always #10 i_clk = ~i_clk;

    // shadow of the header chain
    logic [EW-1:0]     hdr_mem [ARENA_MAX];
    int unsigned       arena_size;
    int unsigned       spill_min;
    t_alloc_result     pending_q[$];
    int unsigned       live_q[$];
    int unsigned       mismatches = 0;
    int unsigned       idle_cycles = 0;
    int unsigned       hold_cycles = 0;
    bit                stall_on = 1'b0;
    bit                hold_req = 1'b0;
    bit                req_taken;

    function automatic int unsigned blk_len(int unsigned p);
        return hdr_mem[p][LW-1:0];
    endfunction

    function automatic bit blk_used(int unsigned p);
        return hdr_mem[p][LW];
    endfunction

    function automatic bit inside_arena(int unsigned p);
        return p + HB <= arena_size;
    endfunction

    function automatic bit succ_is_free(int unsigned p);
        return inside_arena(p) && !blk_used(p);
    endfunction

    function automatic void arena_init(int unsigned bytes);
        if (bytes < ffa_pkg::MIN_ARENA) bytes = ffa_pkg::MIN_ARENA;
        if (bytes > ARENA_MAX) bytes = ARENA_MAX;
        arena_size = bytes;
        foreach (hdr_mem[k]) hdr_mem[k] = '0;
        hdr_mem[0] = EW'(bytes - HB);
    endfunction

    function automatic bit first_fit(int unsigned need, output int unsigned at);
        int unsigned p;
        p = 0;
        at = 0;
        while (inside_arena(p)) begin
            if (!blk_used(p) && blk_len(p) >= need) begin
                at = p;
                return 1'b1;
            end
            p += HB + blk_len(p);
        end
        return 1'b0;
    endfunction

    function automatic bit find_live(int unsigned payload, output int unsigned at);
        int unsigned p;
        p = 0;
        at = 0;
        if (payload < HB) return 1'b0;
        while (inside_arena(p)) begin
            if (p + HB == payload) begin
                at = p;
                return blk_used(p);
            end
            p += HB + blk_len(p);
        end
        return 1'b0;
    endfunction

    function automatic void carve(int unsigned at, int unsigned want);
        int unsigned total, rest;
        total = blk_len(at);
        rest = total - want;
        if (rest < spill_min || rest < HB) want = total;
        else hdr_mem[at + HB + want] = EW'(rest - HB);
        hdr_mem[at] = {1'b1, LW'(want)};
    endfunction

    function automatic void release_block(int unsigned h);
        int unsigned len, nx;
        len = blk_len(h);
        nx = h + HB + len;
        if (succ_is_free(nx)) len += HB + blk_len(nx);
        hdr_mem[h] = {1'b0, LW'(len)};
    endfunction

    // apply one request to the shadow chain and return its answer
    function automatic t_alloc_result apply_request(logic [1:0] fn, int unsigned off,
                                                    int unsigned sz);
        t_alloc_result r;
        int unsigned h, a, len, nx, keep;
        r = '0;
        r.status = ffa_pkg::ST_REJECT;
        case (fn)
            ffa_pkg::FUNC_ALLOC: begin
                if (sz != 0) begin
                    if (first_fit(sz, a)) begin
                        carve(a, sz);
                        r.status = ffa_pkg::ST_DONE;
                        r.result_offset = OW'(a + HB);
                    end else begin
                        r.status = ffa_pkg::ST_NOSPACE;
                    end
                end
            end
            ffa_pkg::FUNC_GROW: begin
                if (sz != 0 && find_live(off, h)) begin
                    len = blk_len(h);
                    nx = h + HB + len;
                    if (succ_is_free(nx) && blk_len(nx) >= sz) begin
                        keep = blk_len(nx) - sz;
                        hdr_mem[h] = {1'b1, LW'(len + sz)};
                        hdr_mem[nx + sz] = EW'(keep);
                        r.status = ffa_pkg::ST_DONE;
                        r.result_offset = OW'(off);
                    end else if (len + sz > 32'h00FF_FFFF || !first_fit(len + sz, a)) begin
                        r.status = ffa_pkg::ST_NOSPACE;
                    end else begin
                        release_block(h);
                        carve(a, len + sz);
                        r.status = ffa_pkg::ST_DONE;
                        r.result_offset = OW'(a + HB);
                        r.move_valid = 1'b1;
                        r.move_from = OW'(off);
                        r.move_length = OW'(len);
                    end
                end
            end
            ffa_pkg::FUNC_FREE: begin
                if (find_live(off, h)) begin
                    len = blk_len(h);
                    if (sz == 0 || sz == len) begin
                        release_block(h);
                        r.status = ffa_pkg::ST_DONE;
                        r.result_offset = OW'(off);
                    end else if (sz >= ffa_pkg::MIN_PARTIAL && sz < len) begin
                        keep = len - sz;
                        nx = h + HB + len;
                        hdr_mem[h] = {1'b1, LW'(keep)};
                        if (succ_is_free(nx))
                            hdr_mem[nx - sz] = EW'(blk_len(nx) + sz);
                        else
                            hdr_mem[h + HB + keep] = EW'(sz - HB);
                        r.status = ffa_pkg::ST_DONE;
                        r.result_offset = OW'(off);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // refresh the list of allocated payload offsets
    function automatic void scan_live();
        int unsigned p;
        p = 0;
        live_q.delete();
        while (inside_arena(p)) begin
            if (blk_used(p)) live_q.push_back(p + HB);
            p += HB + blk_len(p);
        end
    endfunction

    // receive side: result compare
    always @(posedge i_clk) begin
        t_alloc_result got, want;
        if (o_valid && !i_stall && i_rst_n) begin
            got = '{o_status, o_result_offset, o_move_valid, o_move_from, o_move_length};
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("expected %p got %p", want, got);
                end
            end
        end
    end

    // receive side: random stall, occasional long hold, forced long hold
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cycles <= 400;
            i_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_on) begin
            if ($urandom_range(0, 199) == 0) hold_cycles <= $urandom_range(10, 60);
            i_stall <= ($urandom_range(0, 99) < 30);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // offer one request, predict it when taken
    task automatic send_req(logic [1:0] fn, int unsigned off, int unsigned sz);
        int unsigned gap, pick;
        pick = $urandom_range(0, 99);
        gap = (pick < 55) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_func   <= fn;
        i_offset <= OW'(off);
        i_size   <= LW'(sz);
        req_taken = 1'b0;
        while (!req_taken) begin
            @(posedge i_clk);
            req_taken = !o_stall;
        end
        pending_q.push_back(apply_request(fn, off & 12'hFFF, sz & 24'hFF_FFFF));
    endtask

    task automatic wait_drain();
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // write a register between phases
    task automatic write_reg(logic [1:0] idx, int unsigned val);
        i_valid <= 1'b0;
        wait_drain();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= ffa_pkg::CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ffa_pkg::CFG_ARENA) arena_init(val & 13'h1FFF);
        else spill_min = val & 12'hFFF;
    endtask

    function automatic int unsigned any_live();
        scan_live();
        if (live_q.size() == 0) return $urandom_range(0, 4095);
        return live_q[$urandom_range(0, live_q.size() - 1)];
    endfunction

    task automatic test_directed();
        int unsigned a, b;
        send_req(ffa_pkg::FUNC_ALLOC, 0, 0);
        send_req(2'd3, 0, 16);
        send_req(ffa_pkg::FUNC_ALLOC, 4095, 24'hFF_FFFF);
        send_req(ffa_pkg::FUNC_ALLOC, 0, 1);
        send_req(ffa_pkg::FUNC_ALLOC, 0, 64);
        send_req(ffa_pkg::FUNC_ALLOC, 0, 32);
        a = any_live();
        send_req(ffa_pkg::FUNC_GROW, a, 0);
        send_req(ffa_pkg::FUNC_GROW, 0, 8);
        send_req(ffa_pkg::FUNC_GROW, 4095, 8);
        send_req(ffa_pkg::FUNC_FREE, 5, 0);
        send_req(ffa_pkg::FUNC_GROW, live_q[$], 40);
        send_req(ffa_pkg::FUNC_GROW, live_q[0], 100);
        send_req(ffa_pkg::FUNC_GROW, any_live(), 24'hFF_FFFF);
        b = any_live();
        send_req(ffa_pkg::FUNC_FREE, b, 4);
        send_req(ffa_pkg::FUNC_FREE, b, 24'hFF_FFFF);
        send_req(ffa_pkg::FUNC_FREE, b, 8);
        send_req(ffa_pkg::FUNC_FREE, any_live(), 0);
        b = any_live();
        send_req(ffa_pkg::FUNC_FREE, b, blk_len(b - HB));
        send_req(ffa_pkg::FUNC_FREE, b, 0);
        send_req(ffa_pkg::FUNC_ALLOC, 0, 4092);
        send_req(ffa_pkg::FUNC_GROW, 4, 1);
        send_req(ffa_pkg::FUNC_FREE, 4, 0);
    endtask

    task automatic test_random(int unsigned count);
        int unsigned k, pick, off, sz, len;
        logic [1:0] fn;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            fn = (pick < 40) ? ffa_pkg::FUNC_ALLOC : (pick < 65) ? ffa_pkg::FUNC_GROW :
                 (pick < 97) ? ffa_pkg::FUNC_FREE : 2'd3;
            off = ($urandom_range(0, 99) < 88) ? any_live() : $urandom_range(0, 4095);
            pick = $urandom_range(0, 99);
            if (fn == ffa_pkg::FUNC_FREE) begin
                len = (off >= HB) ? blk_len(off - HB) : 0;
                if (pick < 35) sz = 0;
                else if (pick < 55) sz = len;
                else if (pick < 85 && len > ffa_pkg::MIN_PARTIAL)
                    sz = $urandom_range(ffa_pkg::MIN_PARTIAL, len);
                else if (pick < 92) sz = $urandom_range(1, 7);
                else sz = $urandom & 24'hFF_FFFF;
            end else begin
                if (pick < 4) sz = 0;
                else if (pick < 88)
                    sz = $urandom_range(1, (fn == ffa_pkg::FUNC_ALLOC) ? 200 : 80);
                else if (pick < 95) sz = $urandom_range(200, 4096);
                else sz = $urandom & 24'hFF_FFFF;
            end
            send_req(fn, off, sz);
        end
        i_valid <= 1'b0;
    endtask

    task automatic test_backpressure();
        wait_drain();
        @(posedge i_clk);
        hold_req = 1'b1;
        test_random(12);
        wait_drain();
    endtask

    initial begin
        spill_min = ffa_pkg::SPILL_RST;
        arena_init(ffa_pkg::ARENA_RST);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        stall_on = 1'b1;
        test_random(300);
        test_backpressure();
        write_reg(ffa_pkg::CFG_SPILL, 0);
        test_random(300);
        write_reg(ffa_pkg::CFG_SPILL, 4095);
        test_random(150);
        write_reg(ffa_pkg::CFG_ARENA, 0);
        test_random(60);
        write_reg(ffa_pkg::CFG_SPILL, 4);
        write_reg(ffa_pkg::CFG_ARENA, 8);
        test_random(60);
        write_reg(ffa_pkg::CFG_ARENA, 256);
        test_random(250);
        write_reg(ffa_pkg::CFG_ARENA, 8191);
        write_reg(ffa_pkg::CFG_SPILL, 32);
        test_random(400);
        stall_on = 1'b0;
        test_random(150);
        stall_on = 1'b1;
        write_reg(ffa_pkg::CFG_ARENA, 1000);
        write_reg(ffa_pkg::CFG_SPILL, 128);
        test_random(300);
        wait_drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
